// ----- hdl/bdh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdh_pkg;

    // width of the tick threshold registers
    localparam int THR_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 2'd0,
        CFG_HOLD_TICKS     = 2'd1,
        CFG_PIN_INVERT     = 2'd2
    } t_cfg_idx;

    localparam int CFG_DATA_W = THR_W;

    localparam logic [THR_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [THR_W-1:0] HOLD_RESET     = 16'd1000;
    localparam logic             PIN_INVERT_RESET = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] debounce_ticks;
        logic [THR_W-1:0] hold_ticks;
        logic             pin_invert;
    } t_cfg;

    typedef struct packed {
        logic press_pulse;
        logic release_pulse;
        logic hold_pulse;
        logic is_down;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/bdh_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bdh_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/bdh_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bdh_out_if;
    logic valid;
    logic ready;
    logic press_pulse;
    logic release_pulse;
    logic hold_pulse;
    logic is_down;

    modport source (
        output valid, output press_pulse, output release_pulse,
        output hold_pulse, output is_down, input ready
    );
    modport sink (
        input valid, input press_pulse, input release_pulse,
        input hold_pulse, input is_down, output ready
    );
endinterface

`default_nettype wire

// ----- hdl/bdh_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdh_core
    import bdh_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_pin_level,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_raw_level;
    logic                   r_stable_level;
    logic [COUNT_WIDTH-1:0] r_since_change;
    logic [COUNT_WIDTH-1:0] r_since_press;
    logic                   r_hold_done;

    logic                   n_raw_level;
    logic                   n_stable_level;
    logic [COUNT_WIDTH-1:0] n_since_change;
    logic [COUNT_WIDTH-1:0] n_since_press;
    logic                   n_hold_done;

    logic raw;
    logic settle;
    logic hold_clear;
    logic hold_fire;

    always_comb begin
        raw = i_pin_level ^ i_cfg.pin_invert;
        n_raw_level = raw;

        if (raw != r_raw_level) begin
            n_since_change = '0;
        end else if (r_since_change == CNT_MAX) begin
            n_since_change = r_since_change;
        end else begin
            n_since_change = r_since_change + 1'b1;
        end

        settle = (raw != r_stable_level) &&
                 (CMP_W'(n_since_change) >= CMP_W'(i_cfg.debounce_ticks));

        n_stable_level = settle ? raw : r_stable_level;
        hold_clear     = settle ? 1'b0 : r_hold_done;

        // a press restarts the hold timer
        if (settle && raw) begin
            n_since_press = '0;
        end else if (r_since_press == CNT_MAX) begin
            n_since_press = r_since_press;
        end else begin
            n_since_press = r_since_press + 1'b1;
        end

        hold_fire = n_stable_level && !hold_clear &&
                    (CMP_W'(n_since_press) >= CMP_W'(i_cfg.hold_ticks));
        n_hold_done = hold_fire | hold_clear;

        o_result.press_pulse   = settle && raw;
        o_result.release_pulse = settle && !raw;
        o_result.hold_pulse    = hold_fire;
        o_result.is_down       = n_stable_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_level    <= 1'b0;
            r_stable_level <= 1'b0;
            r_since_change <= '0;
            r_since_press  <= '0;
            r_hold_done    <= 1'b0;
        end else if (i_step) begin
            r_raw_level    <= n_raw_level;
            r_stable_level <= n_stable_level;
            r_since_change <= n_since_change;
            r_since_press  <= n_since_press;
            r_hold_done    <= n_hold_done;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/button_debounce_hold_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Push-button debouncer with long-press detection. Each request on i_in is one
// time tick carrying the sampled pin level; each produces exactly one result on
// o_out with press, release and hold pulses and the debounced pressed state.
// The debounce state updates on acceptance; the result sits in an output register,
// offered in the cycle after. A request can be taken every clock cycle as long as
// o_out is ready; a new request is taken in the same cycle the waiting result
// leaves, and the input stalls while a result waits unread. Thresholds, in ticks,
// must be set by the user through the write port while idle; nothing enforces it.
// Reset assumes the button released, debounce 20 ticks, hold 1000, active low.

module button_debounce_hold_top
    import bdh_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bdh_in_if.sink                     i_in,
    bdh_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result step_result;
    t_result r_result;
    logic    r_out_valid;
    logic    step;

    // take a new tick whenever the output slot is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.hold_ticks     <= HOLD_RESET;
            r_cfg.pin_invert     <= PIN_INVERT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data[THR_W-1:0];
                CFG_HOLD_TICKS:     r_cfg.hold_ticks     <= i_cfg_data[THR_W-1:0];
                CFG_PIN_INVERT:     r_cfg.pin_invert     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bdh_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pin_level (i_in.pin_level),
        .i_cfg       (r_cfg),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.press_pulse   = r_result.press_pulse;
    assign o_out.release_pulse = r_result.release_pulse;
    assign o_out.hold_pulse    = r_result.hold_pulse;
    assign o_out.is_down       = r_result.is_down;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bdh_pkg::*;

    localparam int CNT_W          = 16;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TICK_TARGET    = 1900;

    logic                  i_clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_pin   = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bdh_in_if  in_if ();
    bdh_out_if out_if ();

    assign in_if.valid     = in_valid;
    assign in_if.pin_level = in_pin;
    assign out_if.ready    = out_ready;

    button_debounce_hold_top #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // debouncer shadow: settings and state
    logic [THR_W-1:0] sh_debounce   = DEBOUNCE_RESET;
    logic [THR_W-1:0] sh_hold       = HOLD_RESET;
    logic             sh_pin_invert = PIN_INVERT_RESET;
    logic             sh_raw        = 1'b0;
    logic             sh_stable     = 1'b0;
    logic             sh_hold_done  = 1'b0;
    logic [CNT_W-1:0] sh_since_change = '0;
    logic [CNT_W-1:0] sh_since_press  = '0;

    logic    pin_q[$];
    t_result tick_result_q[$];

    logic calm = 1'b0;
    int   errors = 0;
    int   queued = 0;
    int   n_ticks = 0;
    int   n_press = 0;
    int   n_release = 0;
    int   n_hold = 0;
    int   n_settings = 0;
    int   idle_cycles = 0;
    int   holdoff_left = 0;
    bit   holdoff_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    function automatic t_result debounce_tick(logic pin);
        t_result r;
        logic    lvl;
        r   = '0;
        lvl = pin ^ sh_pin_invert;
        if (lvl != sh_raw) begin
            sh_raw = lvl;
            sh_since_change = '0;
        end else if (sh_since_change != '1) begin
            sh_since_change = sh_since_change + 1'b1;
        end
        if (sh_since_press != '1)
            sh_since_press = sh_since_press + 1'b1;
        if (lvl != sh_stable && sh_since_change >= sh_debounce) begin
            sh_stable    = lvl;
            sh_hold_done = 1'b0;
            if (lvl) begin
                sh_since_press = '0;
                r.press_pulse  = 1'b1;
            end else begin
                r.release_pulse = 1'b1;
            end
        end
        if (sh_stable && !sh_hold_done && sh_since_press >= sh_hold) begin
            r.hold_pulse = 1'b1;
            sh_hold_done = 1'b1;
        end
        r.is_down = sh_stable;
        return r;
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (want !== got) begin
            $error("%s expected %0b got %0b", name, want, got);
            errors++;
        end
    endtask

    // pin driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_if.ready) begin
                tick_result_q.push_back(debounce_tick(in_pin));
                n_ticks++;
            end
            if (!in_valid || in_if.ready) begin
                if (pin_q.size() != 0 && (calm || $urandom_range(99, 0) >= 9)) begin
                    in_valid <= 1'b1;
                    in_pin   <= pin_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && out_if.valid) begin
                if (tick_result_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = tick_result_q.pop_front();
                    check_field("press_pulse", want.press_pulse, out_if.press_pulse);
                    check_field("release_pulse", want.release_pulse, out_if.release_pulse);
                    check_field("hold_pulse", want.hold_pulse, out_if.hold_pulse);
                    check_field("is_down", want.is_down, out_if.is_down);
                    n_press   += want.press_pulse;
                    n_release += want.release_pulse;
                    n_hold    += want.hold_pulse;
                end
            end
            // one long hold-off while the pin queue is well stocked
            if (holdoff_left != 0) begin
                holdoff_left--;
                out_ready <= 1'b0;
            end else if (!holdoff_done && pin_q.size() > 60) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99, 0) >= 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && in_if.ready) || (out_ready && out_if.valid)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TICKS: sh_debounce   = val;
            CFG_HOLD_TICKS:     sh_hold       = val;
            CFG_PIN_INVERT:     sh_pin_invert = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(int db, int hold, bit al);
        write_reg(CFG_DEBOUNCE_TICKS, db[CFG_DATA_W-1:0]);
        write_reg(CFG_HOLD_TICKS, hold[CFG_DATA_W-1:0]);
        write_reg(CFG_PIN_INVERT, CFG_DATA_W'(al));
        n_settings++;
    endtask

    // pressed is the logical button state, mapped to the pin per polarity
    task automatic push_level(bit pressed, int n);
        repeat (n) pin_q.push_back(pressed ^ sh_pin_invert);
        queued += n;
    endtask

    task automatic push_pins(logic [31:0] bits, int n);
        for (int i = 0; i < n; i++)
            pin_q.push_back(bits[i]);
        queued += n;
    endtask

    task automatic push_noise(int n);
        repeat (n) pin_q.push_back(1'($urandom_range(1, 0)));
        queued += n;
    endtask

    // bouncy press, steady hold of random length, bouncy release
    task automatic push_press_cycle(int db, int hold);
        int span;
        span = (db > 1) ? db - 1 : 1;
        repeat ($urandom_range(3, 0)) begin
            push_level(1'b1, $urandom_range(span, 1));
            push_level(1'b0, $urandom_range(span, 1));
        end
        push_level(1'b1, db + $urandom_range(hold + 6, 1));
        repeat ($urandom_range(3, 0)) begin
            push_level(1'b0, $urandom_range(span, 1));
            push_level(1'b1, $urandom_range(span, 1));
        end
        push_level(1'b0, db + $urandom_range(6, 1));
    endtask

    task automatic drain();
        while (pin_q.size() != 0 || in_valid || tick_result_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int db;
        int hold;
        int start;
        int target;
        bit al;

        @(posedge rst_n);
        repeat (2) @(posedge i_clk);

        // reset settings: released pin high, short bounce that never settles
        push_pins(32'b10_0111, 6);
        drain();

        // zero thresholds: press and hold on the same tick as the change
        configure(0, 0, 1'b0);
        push_pins(32'b001_0110, 7);
        drain();

        configure(1, 2, 1'b1);
        push_pins(32'b1101_0000, 8);
        drain();

        configure(65535, 65535, 1'b0);
        push_pins(32'b1101, 4);
        drain();

        for (int ph = 0; queued < TICK_TARGET; ph++) begin
            if ($urandom_range(3, 0) == 0) begin
                db   = $urandom_range(40, 15);
                hold = $urandom_range(300, 50);
            end else begin
                db   = $urandom_range(12, 0);
                hold = $urandom_range(40, 0);
            end
            al = 1'($urandom_range(1, 0));
            configure(db, hold, al);
            calm   = (ph == 2);
            start  = queued;
            target = $urandom_range(200, 80);
            while (queued - start < target) begin
                if ($urandom_range(4, 0) == 0)
                    push_noise($urandom_range(8, 1));
                else
                    push_press_cycle(db, hold);
            end
            drain();
        end
        calm = 1'b0;

        // arbitrary register patterns with plain noise
        configure($urandom_range(65535, 0), $urandom_range(65535, 0),
                  1'($urandom_range(1, 0)));
        push_noise(30);
        drain();

        $display("%0d ticks checked across %0d register settings", n_ticks, n_settings);
        $display("%0d presses, %0d releases, %0d long holds seen", n_press, n_release, n_hold);
        if (errors == 0 && tick_result_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
